### sv/tsa_pkg.sv
`timescale 1ns / 1ps

package tsa_pkg;

	localparam int COORD_W       = 17;
	localparam int PREC_W        = 5;
	localparam int PREC_MAX      = 16;
	localparam int FRAC_BITS_DEF = 16;
	localparam int SYM_W         = 3;
	localparam int CNT_W         = 5;

	localparam logic [PREC_W-1:0] PREC_RESET = 5'd3;

	// path symbol codes
	localparam logic [SYM_W-1:0] SYM_T0 = 3'd0;
	localparam logic [SYM_W-1:0] SYM_T1 = 3'd1;
	localparam logic [SYM_W-1:0] SYM_T2 = 3'd2;
	localparam logic [SYM_W-1:0] SYM_T3 = 3'd3;
	localparam logic [SYM_W-1:0] SYM_P0 = 3'd4;
	localparam logic [SYM_W-1:0] SYM_P1 = 3'd5;
	localparam logic [SYM_W-1:0] SYM_P2 = 3'd6;

	typedef struct packed {
		logic load;
		logic step;
	} tsa_cmd_t;

	typedef struct packed {
		logic              vertex;
		logic [PREC_W-1:0] prec;
	} tsa_status_t;

endpackage

### sv/tsa_dp.sv
`timescale 1ns / 1ps

module tsa_dp #(
	parameter int FRAC_BITS = tsa_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [tsa_pkg::PREC_W-1:0]    cfg_wr_data,
	input  logic [tsa_pkg::COORD_W-1:0]   u_coord,
	input  logic [tsa_pkg::COORD_W-1:0]   v_coord,
	input  tsa_pkg::tsa_cmd_t             cmd,
	output tsa_pkg::tsa_status_t          status,
	output logic [tsa_pkg::SYM_W-1:0]     symbol
);

	localparam int XW  = (FRAC_BITS > tsa_pkg::COORD_W ? FRAC_BITS : tsa_pkg::COORD_W) + 1;
	localparam int RW  = 18 + (tsa_pkg::PREC_MAX > FRAC_BITS ? tsa_pkg::PREC_MAX - FRAC_BITS : 0);
	// headroom for up to PREC_MAX doubling steps on points outside the triangle
	localparam int CW  = RW + 19;
	localparam int SHW = $clog2(FRAC_BITS + 1);
	localparam int LW  = $clog2(tsa_pkg::PREC_MAX + 1);
	localparam logic [tsa_pkg::PREC_W-1:0] PREC_CAP = tsa_pkg::PREC_W'(tsa_pkg::PREC_MAX);

	logic [tsa_pkg::PREC_W-1:0] prec_q;
	logic [tsa_pkg::PREC_W-1:0] p;
	logic signed [CW-1:0]       u_q, v_q, w_q;
	logic signed [CW-1:0]       u_nx, v_nx, w_nx;
	logic signed [CW-1:0]       one;
	logic signed [CW-1:0]       u_ld, v_ld, w_ld;
	logic [tsa_pkg::SYM_W-1:0]  sym;
	logic [tsa_pkg::SYM_W-1:0]  symbol_q;

	// half-up rounding from FRAC_BITS to p fraction bits; a plain left shift when p >= FRAC_BITS
	function automatic logic [RW-1:0] round_prec(input logic [tsa_pkg::COORD_W-1:0] x,
		input logic [tsa_pkg::PREC_W-1:0] pp);
		logic [XW-1:0]  sum;
		logic [SHW-1:0] sh;
		logic [LW-1:0]  lsh;
		logic [RW-1:0]  res;
		if (int'(pp) < FRAC_BITS) begin
			sh  = SHW'(FRAC_BITS - int'(pp));
			sum = XW'(x) + (XW'(1) << (sh - SHW'(1)));
			res = RW'(sum >> sh);
		end else begin
			lsh = LW'(int'(pp) - FRAC_BITS);
			res = RW'(x) << lsh;
		end
		return res;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prec_q <= tsa_pkg::PREC_RESET;
		end else if (cfg_wr_en) begin
			prec_q <= cfg_wr_data;
		end
	end

	assign p   = (prec_q > PREC_CAP) ? PREC_CAP : prec_q;
	assign one = signed'(CW'(1) << p);

	always_comb begin
		u_ld = signed'(CW'(round_prec(u_coord, p)));
		v_ld = signed'(CW'(round_prec(v_coord, p)));
		w_ld = one - u_ld - v_ld;
	end

	always_comb begin
		u_nx = u_q;
		v_nx = v_q;
		w_nx = w_q;
		if (u_q == one) begin
			sym = tsa_pkg::SYM_P0;
		end else if (v_q == one) begin
			sym = tsa_pkg::SYM_P1;
		end else if (w_q == one) begin
			sym = tsa_pkg::SYM_P2;
		end else if ((u_q <<< 1) >= one) begin
			sym  = tsa_pkg::SYM_T0;
			u_nx = (u_q <<< 1) - one;
			v_nx = v_q <<< 1;
			w_nx = w_q <<< 1;
		end else if ((v_q <<< 1) >= one) begin
			sym  = tsa_pkg::SYM_T1;
			u_nx = u_q <<< 1;
			v_nx = (v_q <<< 1) - one;
			w_nx = w_q <<< 1;
		end else if ((w_q <<< 1) >= one) begin
			sym  = tsa_pkg::SYM_T2;
			u_nx = u_q <<< 1;
			v_nx = v_q <<< 1;
			w_nx = (w_q <<< 1) - one;
		end else begin
			// centre child: reflect through the midpoint triangle
			sym  = tsa_pkg::SYM_T3;
			u_nx = u_q + v_q - w_q;
			v_nx = v_q + w_q - u_q;
			w_nx = u_q + w_q - v_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			u_q      <= '0;
			v_q      <= '0;
			w_q      <= '0;
			symbol_q <= '0;
		end else begin
			if (cmd.load) begin
				u_q <= u_ld;
				v_q <= v_ld;
				w_q <= w_ld;
			end else if (cmd.step) begin
				u_q <= u_nx;
				v_q <= v_nx;
				w_q <= w_nx;
			end
			if (cmd.step) begin
				symbol_q <= sym;
			end
		end
	end

	assign status.vertex = (sym == tsa_pkg::SYM_P0) || (sym == tsa_pkg::SYM_P1) ||
		(sym == tsa_pkg::SYM_P2);
	assign status.prec   = p;
	assign symbol        = symbol_q;

endmodule

### sv/tsa_ctrl.sv
`timescale 1ns / 1ps

module tsa_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 last,
	output logic                 overrun,
	input  tsa_pkg::tsa_status_t status,
	output tsa_pkg::tsa_cmd_t    cmd
);

	localparam logic [0:0] ST_IDLE = 1'b0;
	localparam logic [0:0] ST_RUN  = 1'b1;

	logic [0:0]                state_q;
	logic [tsa_pkg::CNT_W-1:0] cnt_q;
	logic                      out_valid_q;
	logic                      last_q;
	logic                      overrun_q;
	logic                      final_sym;

	assign in_ready  = (state_q == ST_IDLE);
	assign cmd.load  = in_valid && in_ready;
	assign cmd.step  = (state_q == ST_RUN) && (!out_valid_q || out_ready);
	// last symbol: a vertex, or the precision+1 cap
	assign final_sym = status.vertex || (cnt_q == tsa_pkg::CNT_W'(status.prec));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			last_q      <= 1'b0;
			overrun_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= ST_RUN;
						cnt_q   <= '0;
					end
				end
				ST_RUN: begin
					if (cmd.step && final_sym) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cmd.step) begin
				cnt_q       <= cnt_q + 1'b1;
				out_valid_q <= 1'b1;
				last_q      <= final_sym;
				overrun_q   <= final_sym && !status.vertex;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign last      = last_q;
	assign overrun   = overrun_q;

endmodule

### sv/triangle_subdivision_address.sv
`timescale 1ns / 1ps

// Triangle quadrisection address generator. Each accepted request carries
// barycentric u and v (2^FRAC_BITS = 1.0); they are rounded half-up to
// 'precision' bits (values above 16 act as 16), w = 1 - u - v, and the
// block streams the point's path: child symbols T0..T3 (0..3), ending in a
// vertex symbol P0..P2 (4..6) flagged with last. If no vertex is reached
// within precision+1 symbols, the final child symbol has last and overrun
// set. Timing: the request is first loaded into the step registers, then
// one symbol per cycle from the step datapath while out_ready is high. A
// new request is taken once the final symbol of the previous one sits in
// the output register. The user must write precision through cfg_wr_en/
// cfg_wr_data only while idle; the block itself does not enforce this.

module triangle_subdivision_address #(
	parameter int FRAC_BITS = tsa_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [tsa_pkg::PREC_W-1:0]    cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [tsa_pkg::COORD_W-1:0]   u_coord,
	input  logic [tsa_pkg::COORD_W-1:0]   v_coord,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [tsa_pkg::SYM_W-1:0]     symbol,
	output logic                          last,
	output logic                          overrun
);

	tsa_pkg::tsa_cmd_t    cmd;
	tsa_pkg::tsa_status_t status;

	tsa_dp #(
		.FRAC_BITS(FRAC_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.u_coord    (u_coord),
		.v_coord    (v_coord),
		.cmd        (cmd),
		.status     (status),
		.symbol     (symbol)
	);

	tsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.last     (last),
		.overrun  (overrun),
		.status   (status),
		.cmd      (cmd)
	);

`ifndef SYNTHESIS
	a_overrun_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overrun |-> last)
		else $error("overrun without last");

	a_busy_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while a path is in progress");

	a_vertex_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !overrun |-> (last == (symbol >= tsa_pkg::SYM_P0)))
		else $error("path end does not match vertex symbol");

	a_no_step_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !cmd.step)
		else $error("datapath stepped while idle");
`endif

endmodule
